### rtl/bsfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder package
// Shared types, register map and constants of the frame encoder.
// ----------------------------------------------------------------------------
package bsfe_pkg;

  localparam int unsigned SEQ_SHIFT  = 6;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned FIFO_DEPTH = 2;

  typedef enum logic [2:0] {
    REG_FLAG   = 3'd0,
    REG_ESCAPE = 3'd1,
    REG_MASK   = 3'd2,
    REG_ADDR   = 3'd3,
    REG_CTRL   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] flag_byte;
    logic [7:0] escape_byte;
    logic [7:0] stuff_mask;
    logic [7:0] address_value;
    logic [7:0] info_control_base;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    flag_byte:         8'h7E,
    escape_byte:       8'h7D,
    stuff_mask:        8'h20,
    address_value:     8'h03,
    info_control_base: 8'h00
  };

  // One classified transaction handed from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] check;
    logic       first;
    logic       last;
    logic       seq;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

endpackage

### rtl/bsfe_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder channels
// Valid/ready channels for payload input and line byte output.
// ----------------------------------------------------------------------------
interface bsfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       frame_last;
  logic       seq_bit;

  modport source (output valid, output payload_byte, output frame_last, output seq_bit,
                  input ready);
  modport sink (input valid, input payload_byte, input frame_last, input seq_bit,
                output ready);
endinterface

interface bsfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       run_last;
  logic       close_flag;

  modport source (output valid, output line_byte, output run_last, output close_flag,
                  input ready);
  modport sink (input valid, input line_byte, input run_last, input close_flag,
                output ready);
endinterface

### rtl/bsfe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder front end
// Accepts payload bytes, tracks frame position and the running payload check.
// ----------------------------------------------------------------------------
module bsfe_front
  import bsfe_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  bsfe_in_if.sink      in_chan_i,
  input  fifo_status_t fifo_status_i,
  output logic         push_o,
  output entry_t       push_entry_o
);

  logic       inside_q, inside_d;
  logic [7:0] check_q, check_d;
  logic [7:0] check_new;
  logic       accept;

  assign in_chan_i.ready = !fifo_status_i.full;
  assign accept          = in_chan_i.valid && in_chan_i.ready;
  assign check_new       = (inside_q ? check_q : 8'h00) ^ in_chan_i.payload_byte;

  always_comb begin
    push_o             = accept;
    push_entry_o.data  = in_chan_i.payload_byte;
    push_entry_o.check = check_new;
    push_entry_o.first = !inside_q;
    push_entry_o.last  = in_chan_i.frame_last;
    push_entry_o.seq   = in_chan_i.seq_bit;
    inside_d           = inside_q;
    check_d            = check_q;
    if (accept) begin
      inside_d = !in_chan_i.frame_last;
      check_d  = in_chan_i.frame_last ? 8'h00 : check_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      check_q  <= 8'h00;
    end else begin
      inside_q <= inside_d;
      check_q  <= check_d;
    end
  end

endmodule

### rtl/bsfe_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder queue
// Short queue of classified transactions between the front and the back.
// ----------------------------------------------------------------------------
module bsfe_fifo
  import bsfe_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  entry_t       push_entry_i,
  input  logic         pop_i,
  output entry_t       head_o,
  output fifo_status_t status_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  entry_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CNT_W'(FIFO_DEPTH));

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### rtl/bsfe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder back end
// Steps through the bytes of each transaction and stuffs them onto the line.
// ----------------------------------------------------------------------------
module bsfe_back
  import bsfe_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  entry_t       head_i,
  input  fifo_status_t fifo_status_i,
  output logic         pop_o,
  bsfe_out_if.source   out_chan_o
);

  typedef enum logic [7:0] {
    ST_START = 8'b0000_0001,
    ST_OPEN  = 8'b0000_0010,
    ST_ADDR  = 8'b0000_0100,
    ST_CTRL  = 8'b0000_1000,
    ST_HCS   = 8'b0001_0000,
    ST_DATA  = 8'b0010_0000,
    ST_CHECK = 8'b0100_0000,
    ST_CLOSE = 8'b1000_0000
  } slot_e;

  slot_e      state_q, state_d;
  slot_e      cur_slot;
  slot_e      next_slot;
  logic       esc_q, esc_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       run_last_q, run_last_d;
  logic       close_flag_q, close_flag_d;
  logic [7:0] control;
  logic [7:0] raw;
  logic       stuffable;
  logic       needs_esc;
  logic       slot_done;
  logic       entry_done;
  logic       fire;

  assign control  = cfg_i.info_control_base | (8'(head_i.seq) << SEQ_SHIFT);
  assign cur_slot = (state_q == ST_START) ? (head_i.first ? ST_OPEN : ST_DATA) : state_q;
  assign fire     = !fifo_status_i.empty && (!valid_q || out_chan_o.ready);

  always_comb begin
    raw       = head_i.data;
    stuffable = 1'b1;
    next_slot = ST_START;
    case (cur_slot)
      ST_OPEN: begin
        raw       = cfg_i.flag_byte;
        stuffable = 1'b0;
        next_slot = ST_ADDR;
      end
      ST_ADDR: begin
        raw       = cfg_i.address_value;
        next_slot = ST_CTRL;
      end
      ST_CTRL: begin
        raw       = control;
        next_slot = ST_HCS;
      end
      ST_HCS: begin
        raw       = cfg_i.address_value ^ control;
        next_slot = ST_DATA;
      end
      ST_DATA: begin
        raw       = head_i.data;
        next_slot = head_i.last ? ST_CHECK : ST_START;
      end
      ST_CHECK: begin
        raw       = head_i.check;
        next_slot = ST_CLOSE;
      end
      ST_CLOSE: begin
        raw       = cfg_i.flag_byte;
        stuffable = 1'b0;
        next_slot = ST_START;
      end
      default: begin
        raw       = head_i.data;
        stuffable = 1'b0;
        next_slot = ST_START;
      end
    endcase
  end

  assign needs_esc  = stuffable && (raw == cfg_i.flag_byte || raw == cfg_i.escape_byte);
  assign slot_done  = esc_q || !needs_esc;
  assign entry_done = slot_done && (next_slot == ST_START);
  assign pop_o      = fire && entry_done;

  always_comb begin
    state_d      = state_q;
    esc_d        = esc_q;
    byte_d       = byte_q;
    run_last_d   = run_last_q;
    close_flag_d = close_flag_q;
    valid_d      = valid_q && !out_chan_o.ready;
    if (fire) begin
      valid_d      = 1'b1;
      run_last_d   = entry_done;
      close_flag_d = (cur_slot == ST_CLOSE);
      if (esc_q) begin
        byte_d = raw ^ cfg_i.stuff_mask;
      end else if (needs_esc) begin
        byte_d = cfg_i.escape_byte;
      end else begin
        byte_d = raw;
      end
      esc_d   = !slot_done;
      state_d = slot_done ? next_slot : cur_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
      esc_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      esc_q   <= esc_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q       <= byte_d;
    run_last_q   <= run_last_d;
    close_flag_q <= close_flag_d;
  end

  assign out_chan_o.valid      = valid_q;
  assign out_chan_o.line_byte  = byte_q;
  assign out_chan_o.run_last   = run_last_q;
  assign out_chan_o.close_flag = close_flag_q;

endmodule

### rtl/byte_stuffed_info_frame_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed information frame encoder
// Frames payload bytes with flags, header, payload check and byte stuffing.
// ----------------------------------------------------------------------------
// Path: an accepted transaction is written into the queue, and the back end then registers
// each of its line bytes in its single output register.
// Throughput: one line byte per cycle while the output is ready and the queue holds a
// transaction; a transaction causes 1 to 12 line bytes, which the back end steps through.
// Reset: asynchronous and active low; the configuration registers return to their defaults and the
// queue and frame state are cleared at once, with no clearing pass.
module byte_stuffed_info_frame_encoder_top
  import bsfe_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  bsfe_in_if.sink           in_chan_i,
  bsfe_out_if.source        out_chan_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t         cfg_q, cfg_d;
  fifo_status_t fifo_status;
  entry_t       push_entry;
  entry_t       head;
  logic         push;
  logic         pop;
  logic [2:0]   reg_idx;
  logic         wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_FLAG:   cfg_d.flag_byte         = pwdata[7:0];
        REG_ESCAPE: cfg_d.escape_byte       = pwdata[7:0];
        REG_MASK:   cfg_d.stuff_mask        = pwdata[7:0];
        REG_ADDR:   cfg_d.address_value     = pwdata[7:0];
        REG_CTRL:   cfg_d.info_control_base = pwdata[7:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FLAG:   prdata = {24'h0, cfg_q.flag_byte};
      REG_ESCAPE: prdata = {24'h0, cfg_q.escape_byte};
      REG_MASK:   prdata = {24'h0, cfg_q.stuff_mask};
      REG_ADDR:   prdata = {24'h0, cfg_q.address_value};
      REG_CTRL:   prdata = {24'h0, cfg_q.info_control_base};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bsfe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_chan_i     (in_chan_i),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .push_entry_o  (push_entry)
  );

  bsfe_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (fifo_status)
  );

  bsfe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_i        (head),
    .fifo_status_i (fifo_status),
    .pop_o         (pop),
    .out_chan_o    (out_chan_o)
  );

  a_close_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_chan_o.valid && out_chan_o.close_flag |-> out_chan_o.run_last)
    else $error("Closing flag not marked as the last byte of its transaction.");

  a_close_is_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_chan_o.valid && out_chan_o.close_flag |-> out_chan_o.line_byte == cfg_q.flag_byte)
    else $error("Closing byte differs from the flag byte.");

  a_queue_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fifo_status.empty && !out_chan_o.valid |=> out_chan_o.valid)
    else $error("Back end idle while the queue holds a transaction.");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_status.empty)
    else $error("Queue popped while empty.");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed information frame encoder testbench
// Sends frames of payload bytes through the input channel, predicts the
// stuffed line bytes of every accepted transaction and checks each line byte
// in order, under several register settings and idling patterns. Register
// writes are read back over the same port.
// ----------------------------------------------------------------------------
module testbench;
  import bsfe_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       seq;
  } payload_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       close_flag;
  } line_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bsfe_in_if  in_chan ();
  bsfe_out_if out_chan ();

  payload_t    payload_q[$];
  line_t       line_q[$];
  payload_t    next_item;
  cfg_t        cfg_now = CFG_RESET;
  logic        in_frame = 1'b0;
  logic [7:0]  frame_check = 8'h00;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count = 0;

  byte_stuffed_info_frame_encoder_top DUT (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_chan_i (in_chan),
    .out_chan_o(out_chan),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    error_count++;
  endtask

  function automatic void push_line(logic [7:0] b, logic fe);
    line_q.push_back('{b, 1'b0, fe});
  endfunction

  function automatic void push_stuffed(logic [7:0] b);
    if (b == cfg_now.flag_byte || b == cfg_now.escape_byte) begin
      push_line(cfg_now.escape_byte, 1'b0);
      push_line(b ^ cfg_now.stuff_mask, 1'b0);
    end else begin
      push_line(b, 1'b0);
    end
  endfunction

  // Appends the line bytes that one accepted payload transaction causes.
  function automatic void encode_payload(logic [7:0] data, logic last, logic seq);
    logic [7:0] control;
    if (!in_frame) begin
      control = cfg_now.info_control_base | ({7'b0, seq} << SEQ_SHIFT);
      push_line(cfg_now.flag_byte, 1'b0);
      push_stuffed(cfg_now.address_value);
      push_stuffed(control);
      push_stuffed(cfg_now.address_value ^ control);
      frame_check = 8'h00;
      in_frame = 1'b1;
    end
    push_stuffed(data);
    frame_check = frame_check ^ data;
    if (last) begin
      push_stuffed(frame_check);
      push_line(cfg_now.flag_byte, 1'b1);
      in_frame = 1'b0;
      frame_check = 8'h00;
    end
    line_q[line_q.size() - 1].run_last = 1'b1;
  endfunction

  function automatic void queue_payload(logic [7:0] data, logic last, logic seq);
    payload_q.push_back('{data, last, seq});
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        encode_payload(in_chan.payload_byte, in_chan.frame_last, in_chan.seq_bit);
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (payload_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          next_item = payload_q.pop_front();
          in_chan.valid        <= 1'b1;
          in_chan.payload_byte <= next_item.data;
          in_chan.frame_last   <= next_item.last;
          in_chan.seq_bit      <= next_item.seq;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_line_byte(logic [7:0] b, logic rl, logic fe);
    line_t want;
    if (line_q.size() == 0) begin
      report_mismatch($sformatf("unexpected line byte %02h", b));
    end else begin
      want = line_q.pop_front();
      if (b !== want.data)
        report_mismatch($sformatf("line_byte %02h, wanted %02h", b, want.data));
      if (rl !== want.run_last)
        report_mismatch($sformatf("run_last %b, wanted %b (byte %02h)", rl, want.run_last,
                                  want.data));
      if (fe !== want.close_flag)
        report_mismatch($sformatf("close_flag %b, wanted %b (byte %02h)", fe,
                                  want.close_flag, want.data));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        check_line_byte(out_chan.line_byte, out_chan.run_last, out_chan.close_flag);
      end
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (payload_q.size() != 0 || in_chan.valid || line_q.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_register(reg_idx_e idx, logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FLAG:   cfg_now.flag_byte = value;
      REG_ESCAPE: cfg_now.escape_byte = value;
      REG_MASK:   cfg_now.stuff_mask = value;
      REG_ADDR:   cfg_now.address_value = value;
      REG_CTRL:   cfg_now.info_control_base = value;
      default:    ;
    endcase
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[7:0] !== value)
      report_mismatch($sformatf("register %s read %02h, wanted %02h", idx.name(),
                                prdata[7:0], value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] flag, logic [7:0] esc, logic [7:0] mask,
                            logic [7:0] addr, logic [7:0] ctrl);
    write_register(REG_FLAG, flag);
    write_register(REG_ESCAPE, esc);
    write_register(REG_MASK, mask);
    write_register(REG_ADDR, addr);
    write_register(REG_CTRL, ctrl);
    @(negedge clk);
  endtask

  initial begin
    int unsigned phase_items;
    int unsigned frame_len;
    int unsigned r;
    logic [7:0]  b;
    logic [7:0]  f;
    logic        paused;
    in_chan.valid        = 1'b0;
    in_chan.payload_byte = 8'h00;
    in_chan.frame_last   = 1'b0;
    in_chan.seq_bit      = 1'b0;
    out_chan.ready       = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: payload equal to flag and escape, extremes, sequence bit
    // changing inside a frame.
    queue_payload(8'h7E, 1'b1, 1'b0);
    queue_payload(8'h7D, 1'b0, 1'b1);
    queue_payload(8'h00, 1'b0, 1'b0);
    queue_payload(8'hFF, 1'b0, 1'b0);
    queue_payload(8'h20, 1'b1, 1'b1);
    wait_idle();

    // Header bytes that need stuffing.
    set_config(8'h7E, 8'h7D, 8'h20, 8'h7D, 8'h3E);
    queue_payload(8'h11, 1'b1, 1'b1);
    wait_idle();

    // Flag equal to escape.
    set_config(8'h55, 8'h55, 8'hFF, 8'h55, 8'h15);
    queue_payload(8'h55, 1'b0, 1'b0);
    queue_payload(8'hAA, 1'b0, 1'b1);
    queue_payload(8'h55, 1'b1, 1'b0);
    wait_idle();

    // Register written while a frame is open.
    queue_payload(8'h10, 1'b0, 1'b1);
    queue_payload(8'h7E, 1'b0, 1'b0);
    wait_idle();
    write_register(REG_FLAG, 8'h10);
    @(negedge clk);
    queue_payload(8'h10, 1'b1, 1'b0);
    wait_idle();

    set_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_payload(8'h00, 1'b0, 1'b1);
    queue_payload(8'hFF, 1'b1, 1'b0);
    wait_idle();

    set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_payload(8'hFF, 1'b0, 1'b1);
    queue_payload(8'h00, 1'b0, 1'b0);
    queue_payload(8'h01, 1'b1, 1'b1);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 74; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 74; end
        default: begin send_gap_pct = 23; recv_stall_pct = 23; end
      endcase
      f = 8'($urandom_range(255));
      case (p)
        0: set_config(CFG_RESET.flag_byte, CFG_RESET.escape_byte, CFG_RESET.stuff_mask,
                      CFG_RESET.address_value, CFG_RESET.info_control_base);
        2: set_config(8'h00, 8'hFF, 8'h80, 8'($urandom_range(255)), 8'($urandom_range(255)));
        3: set_config(f, f, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
        default: set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255)));
      endcase
      phase_items = 0;
      paused = 1'b0;
      while (phase_items < 48) begin
        r = $urandom_range(99);
        frame_len = (r < 30) ? 1 : (r < 85) ? $urandom_range(6, 2) : $urandom_range(24, 7);
        @(negedge clk);
        for (int i = 0; i < frame_len; i++) begin
          r = $urandom_range(99);
          if (r < 15)      b = cfg_now.flag_byte;
          else if (r < 30) b = cfg_now.escape_byte;
          else if (r < 35) b = 8'h00;
          else if (r < 40) b = 8'hFF;
          else             b = 8'($urandom_range(255));
          queue_payload(b, i == frame_len - 1, 1'($urandom_range(1)));
        end
        phase_items += frame_len;
        // The sender holds off here until the line side has drained.
        if (p == 5 && !paused && phase_items >= 24) begin
          wait_idle();
          paused = 1'b1;
        end
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
